[design/bsa_pkg.sv]
// shared types and constants of the bitmap slot allocator
package bsa_pkg;

  localparam int NUM_W  = 9;
  localparam int CFG_W  = 5;
  localparam int OP_W   = 2;
  localparam int POS_W  = 8;
  localparam int STAT_W = 3;
  localparam int SLOT_W = 5;

  localparam logic [CFG_W-1:0] ROWS_RST  = 5'd10;
  localparam logic [CFG_W-1:0] SLOTS_RST = 5'd10;

  typedef enum logic {
    CFG_ROWS  = 1'b0,
    CFG_SLOTS = 1'b1
  } cfg_idx_t;

  typedef enum logic [OP_W-1:0] {
    OP_CLAIM   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_GROUP   = 2'd2
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 3'd0,
    STAT_INVALID = 3'd1,
    STAT_TAKEN   = 3'd2,
    STAT_FREE    = 3'd3,
    STAT_NOROOM  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } ctl_state_t;

  typedef struct packed {
    logic accept;
    logic commit;
  } bsa_cmd_t;

endpackage

[design/bitmap_slot_allocator_first_fit_top.sv]
// top level of the first-fit bitmap slot allocator
// Occupancy map of MAX_ROWS row words, one bit per slot, held in a single-port
// row memory with a registered read. A request is taken in S_IDLE, which
// starts the row read; in S_EXEC the row is checked, the first-fit window
// search runs and the row is written back while the result register loads,
// once it is free. No new request is taken until the previous one commits,
// set by the read-modify-write of the row memory. The result register lets
// a new request enter while the previous result waits. The map is empty
// after reset through per-row valid flags, so no clearing pass is needed.
module bitmap_slot_allocator_first_fit_top #(
  parameter int MAX_ROWS  = 16,
  parameter int MAX_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // row_number, slot_number, group_size
  input  logic [1:0]  in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // status, first_slot, last_slot, zero pad
);

  bsa_pkg::bsa_cmd_t cmd;
  logic [bsa_pkg::STAT_W-1:0] status;
  logic [bsa_pkg::SLOT_W-1:0] first_slot, last_slot;

  bsa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  bsa_datapath #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_op      (in_tuser),
    .in_row     (in_tdata[7:0]),
    .in_slot    (in_tdata[15:8]),
    .in_size    (in_tdata[23:16]),
    .cmd        (cmd),
    .out_status (status),
    .out_first  (first_slot),
    .out_last   (last_slot)
  );

  assign out_tdata = {3'b000, last_slot, first_slot, status};

endmodule

[design/bsa_ctrl.sv]
// controller: request sequencing and result handshake
module bsa_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  output bsa_pkg::bsa_cmd_t cmd
);

  bsa_pkg::ctl_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == bsa_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd.accept = in_tvalid && (state_r == bsa_pkg::S_IDLE);
    cmd.commit = (state_r == bsa_pkg::S_EXEC) && (!out_valid_r || out_tready);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bsa_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = bsa_pkg::S_EXEC;
      end
      bsa_pkg::S_EXEC: begin
        if (cmd.commit) state_nxt = bsa_pkg::S_IDLE;
      end
      default: state_nxt = bsa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.commit) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsa_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == bsa_pkg::S_EXEC))
    else $error("accepted beat did not start execution");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bsa_pkg::S_EXEC && out_valid_r && !out_tready)
      |=> (state_r == bsa_pkg::S_EXEC))
    else $error("execution left while result register was blocked");

  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit did not present a result");

endmodule

[design/bsa_datapath.sv]
// datapath: config registers, row memory, slot checks and first-fit search
module bsa_datapath #(
  parameter int MAX_ROWS  = 16,
  parameter int MAX_SLOTS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [bsa_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic [bsa_pkg::OP_W-1:0]      in_op,
  input  logic [bsa_pkg::POS_W-1:0]     in_row,
  input  logic [bsa_pkg::POS_W-1:0]     in_slot,
  input  logic [bsa_pkg::POS_W-1:0]     in_size,
  input  bsa_pkg::bsa_cmd_t             cmd,
  output logic [bsa_pkg::STAT_W-1:0]    out_status,
  output logic [bsa_pkg::SLOT_W-1:0]    out_first,
  output logic [bsa_pkg::SLOT_W-1:0]    out_last
);

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int NW = bsa_pkg::NUM_W;

  logic [bsa_pkg::CFG_W-1:0] cfg_rows_r, cfg_slots_r;

  logic [MAX_SLOTS-1:0] mem [MAX_ROWS];
  logic [MAX_ROWS-1:0]  row_vld_r;
  logic [MAX_SLOTS-1:0] mem_rd_r;
  logic                 vld_rd_r;

  logic [bsa_pkg::OP_W-1:0]  op_r;
  logic [bsa_pkg::POS_W-1:0] row_r, slot_r, size_r;
  logic [RW-1:0]             idx_r;
  logic [RW-1:0]             idx_in;

  logic [bsa_pkg::STAT_W-1:0] status_r, status_nxt;
  logic [bsa_pkg::SLOT_W-1:0] first_r, first_nxt, last_r, last_nxt;

  logic [MAX_SLOTS-1:0] word, new_word, bit_vec, win_sel;
  logic [MAX_SLOTS-1:0] fit;
  logic [NW-1:0]        rows_eff, cols_eff, row_w, slot_w, size_w;
  logic                 row_ok, slot_ok, size_ok, any_fit, wr_en;
  logic [SW-1:0]        bit_idx, pos;
  logic [NW-1:0]        pos_w;

  assign idx_in = RW'(in_row - 8'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_rows_r  <= bsa_pkg::ROWS_RST;
      cfg_slots_r <= bsa_pkg::SLOTS_RST;
    end else if (cfg_we) begin
      if (cfg_index == bsa_pkg::CFG_ROWS) cfg_rows_r <= cfg_wdata;
      else cfg_slots_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r     <= in_op;
      row_r    <= in_row;
      slot_r   <= in_slot;
      size_r   <= in_size;
      idx_r    <= idx_in;
      vld_rd_r <= row_vld_r[idx_in];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) mem_rd_r <= mem[idx_in];
    if (wr_en) mem[idx_r] <= new_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) row_vld_r <= '0;
    else if (wr_en) row_vld_r[idx_r] <= 1'b1;
  end

  always_comb begin
    word     = vld_rd_r ? mem_rd_r : '0;
    row_w    = NW'(row_r);
    slot_w   = NW'(slot_r);
    size_w   = NW'(size_r);
    rows_eff = (NW'(cfg_rows_r) > NW'(MAX_ROWS)) ? NW'(MAX_ROWS) : NW'(cfg_rows_r);
    cols_eff = (NW'(cfg_slots_r) > NW'(MAX_SLOTS)) ? NW'(MAX_SLOTS) : NW'(cfg_slots_r);
    row_ok   = (row_w != '0) && (row_w <= rows_eff);
    slot_ok  = (slot_w != '0) && (slot_w <= cols_eff);
    size_ok  = (size_w <= cols_eff);
    bit_idx  = SW'(slot_r - 8'd1);
    bit_vec  = MAX_SLOTS'(1) << bit_idx;
  end

  // window fit at every start position, lowest one wins
  always_comb begin
    logic [MAX_SLOTS-1:0] win;
    fit = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      for (int j = 0; j < MAX_SLOTS; j++) begin
        win[j] = (j >= i) && (NW'(j) < NW'(i) + size_w);
      end
      fit[i] = ((word & win) == '0) && (NW'(i) + size_w <= cols_eff);
    end
    any_fit = |fit;
    pos = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (fit[i]) pos = SW'(i);
    end
    pos_w = NW'(pos);
    for (int j = 0; j < MAX_SLOTS; j++) begin
      win_sel[j] = (NW'(j) >= pos_w) && (NW'(j) < pos_w + size_w);
    end
  end

  always_comb begin
    status_nxt = bsa_pkg::STAT_INVALID;
    first_nxt  = '0;
    last_nxt   = '0;
    new_word   = word;
    case (op_r)
      bsa_pkg::OP_CLAIM: begin
        if (row_ok && slot_ok) begin
          if ((word & bit_vec) != '0) begin
            status_nxt = bsa_pkg::STAT_TAKEN;
          end else begin
            status_nxt = bsa_pkg::STAT_OK;
            new_word   = word | bit_vec;
            first_nxt  = slot_r[bsa_pkg::SLOT_W-1:0];
            last_nxt   = slot_r[bsa_pkg::SLOT_W-1:0];
          end
        end
      end
      bsa_pkg::OP_RELEASE: begin
        if (row_ok && slot_ok) begin
          if ((word & bit_vec) == '0) begin
            status_nxt = bsa_pkg::STAT_FREE;
          end else begin
            status_nxt = bsa_pkg::STAT_OK;
            new_word   = word & ~bit_vec;
            first_nxt  = slot_r[bsa_pkg::SLOT_W-1:0];
            last_nxt   = slot_r[bsa_pkg::SLOT_W-1:0];
          end
        end
      end
      bsa_pkg::OP_GROUP: begin
        if (row_ok && size_ok) begin
          if (size_r == '0) begin
            status_nxt = bsa_pkg::STAT_OK;
            first_nxt  = bsa_pkg::SLOT_W'(1);
          end else if (any_fit) begin
            status_nxt = bsa_pkg::STAT_OK;
            new_word   = word | win_sel;
            first_nxt  = bsa_pkg::SLOT_W'(pos_w + NW'(1));
            last_nxt   = bsa_pkg::SLOT_W'(pos_w + size_w);
          end else begin
            status_nxt = bsa_pkg::STAT_NOROOM;
          end
        end
      end
      default: status_nxt = bsa_pkg::STAT_INVALID;
    endcase
  end

  assign wr_en = cmd.commit && (status_nxt == bsa_pkg::STAT_OK) && (new_word != word);

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r <= status_nxt;
      first_r  <= first_nxt;
      last_r   <= last_nxt;
    end
  end

  assign out_status = status_r;
  assign out_first  = first_r;
  assign out_last   = last_r;

endmodule
